FILE: sv/gamepad_report_to_pad_and_quadrature_assert.svh
// Assertion macros for the checker file of the pad and quadrature block.
`ifndef GAMEPAD_REPORT_TO_PAD_AND_QUADRATURE_ASSERT_SVH
`define GAMEPAD_REPORT_TO_PAD_AND_QUADRATURE_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define GPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpq assertion failed");

// Next-cycle implication, disabled while rst is high.
`define GPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpq assertion failed");

`endif

FILE: sv/gpq_pkg.sv
// Shared constants, types and button bit positions for the pad and quadrature block.
package gpq_pkg;

   localparam int NUM_BYTES          = 6;
   localparam int REPORT_W           = 15;
   localparam int PAD_W              = 8;
   localparam int RING_DEPTH_DEFAULT = 8;

   localparam logic [7:0] SCRAMBLE_KEY = 8'h17;
   localparam logic [7:0] ALL_ONES     = 8'hFF;

   // Bytes carrying button bits
   localparam int BTN_BYTE_HI = 4;
   localparam int BTN_BYTE_LO = 5;

   // Configuration register indexes
   localparam logic CSR_JUMP_RUN = 1'b0;
   localparam logic CSR_DELAY    = 1'b1;

   // Report bit positions
   localparam int REP_X      = 0;
   localparam int REP_A      = 1;
   localparam int REP_B      = 2;
   localparam int REP_Y      = 3;
   localparam int REP_START  = 4;
   localparam int REP_SELECT = 5;
   localparam int REP_HOME   = 6;
   localparam int REP_RTRIG  = 7;
   localparam int REP_LTRIG  = 8;
   localparam int REP_RZ     = 9;
   localparam int REP_LZ     = 10;
   localparam int REP_UP     = 11;
   localparam int REP_DOWN   = 12;
   localparam int REP_LEFT   = 13;
   localparam int REP_RIGHT  = 14;

   // Pad pin positions
   localparam int PAD_C     = 0;
   localparam int PAD_START = 1;
   localparam int PAD_B     = 2;
   localparam int PAD_A     = 3;
   localparam int PAD_RIGHT = 4;
   localparam int PAD_LEFT  = 5;
   localparam int PAD_DOWN  = 6;
   localparam int PAD_UP    = 7;

   typedef logic [REPORT_W-1:0] report_type;
   typedef logic [NUM_BYTES-1:0][7:0] poll_type;

   typedef struct packed {
      report_type report;
      logic       all_ones;
   } merge_type;

   typedef struct packed {
      report_type newest;
      report_type oldest;
   } ring_view_type;

endpackage

FILE: sv/gpq_lane.sv
// One byte lane: unscrambles a poll byte and flags an all-ones result.
module gpq_lane
   import gpq_pkg::*;
(
   input  logic [7:0] raw_byte,
   output logic [7:0] clear_byte,
   output logic       is_ones
);

   always_comb begin
      clear_byte = (raw_byte ^ SCRAMBLE_KEY) + SCRAMBLE_KEY;
      is_ones    = (clear_byte == ALL_ONES);
   end

endmodule

FILE: sv/gpq_merge.sv
// Merges the byte lanes: all-ones test over the poll and button report unpacking.
module gpq_merge
   import gpq_pkg::*;
(
   input  poll_type               clear_bytes,
   input  logic [NUM_BYTES-1:0]   lane_ones,
   output merge_type              merged
);

   logic [7:0] p4;
   logic [7:0] p5;

   always_comb begin
      // button bits are active low
      p4 = ~clear_bytes[BTN_BYTE_HI];
      p5 = ~clear_bytes[BTN_BYTE_LO];

      merged.all_ones                 = &lane_ones;
      merged.report                   = '0;
      merged.report[REP_X]      = p5[3];
      merged.report[REP_A]      = p5[4];
      merged.report[REP_B]      = p5[6];
      merged.report[REP_Y]      = p5[5];
      merged.report[REP_START]  = p4[2];
      merged.report[REP_SELECT] = p4[4];
      merged.report[REP_HOME]   = p4[3];
      merged.report[REP_RTRIG]  = p4[1];
      merged.report[REP_LTRIG]  = p4[5];
      merged.report[REP_RZ]     = p5[2];
      merged.report[REP_LZ]     = p5[7];
      merged.report[REP_UP]     = p5[0];
      merged.report[REP_DOWN]   = p4[6];
      merged.report[REP_LEFT]   = p5[1];
      merged.report[REP_RIGHT]  = p4[7];
   end

endmodule

FILE: sv/gpq_ring.sv
// Report history held as a shift line: tap 0 is the newest report, the last tap the oldest.
module gpq_ring
   import gpq_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  report_type    report,
   input  logic          clear,
   output ring_view_type view
);

   report_type taps_ff [RING_DEPTH];
   report_type taps_in [RING_DEPTH];

   // view after this request's push, before any clear
   always_comb begin
      view.newest = push ? report : taps_ff[0];
      view.oldest = push ? taps_ff[RING_DEPTH-2] : taps_ff[RING_DEPTH-1];
   end

   always_comb begin
      taps_in[0] = push ? report : taps_ff[0];
      for (int i = 1; i < RING_DEPTH; i++) begin
         taps_in[i] = push ? taps_ff[i-1] : taps_ff[i];
      end
      if (clear) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            taps_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            taps_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            taps_ff[i] <= taps_in[i];
         end
      end
   end

endmodule

FILE: sv/gamepad_report_to_pad_and_quadrature.sv
// Top level: controller poll to pad drive and two-axis quadrature outputs.
// Takes one poll request per clock and returns one response per request, in the cycle
// after acceptance, through a single output register; a new request is accepted
// whenever that register is empty or being taken in the same cycle. Six byte lanes
// unscramble the poll in parallel, a merge stage builds the button report and the
// all-0xFF test, and the report history is a RING_DEPTH-tap shift line, so the
// newest and oldest reports are always at fixed taps. Configuration writes act at
// once and are meant to be made while no response is pending.
module gamepad_report_to_pad_and_quadrature
   import gpq_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic        csr_write_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte0,
   input  logic [7:0]  req_byte1,
   input  logic [7:0]  req_byte2,
   input  logic [7:0]  req_byte3,
   input  logic [7:0]  req_byte4,
   input  logic [7:0]  req_byte5,
   input  logic        req_read_ok,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_buttons_now,
   output logic [7:0]  rsp_pad_pressed,
   output logic        rsp_horiz_phase,
   output logic        rsp_horiz_quad,
   output logic        rsp_vert_phase,
   output logic        rsp_vert_quad,
   output logic        rsp_resync
);

   poll_type             raw_bytes;
   poll_type             clear_bytes;
   logic [NUM_BYTES-1:0] lane_ones;
   merge_type            merged;
   ring_view_type        view;

   logic       accept;
   logic       resync_now;
   report_type shown;
   logic [7:0] pad_now;

   logic       jump_run_ff, jump_run_in;
   logic       delay_ff, delay_in;
   logic       last_ones_ff, last_ones_in;
   logic [1:0] horiz_ff, horiz_in;
   logic [1:0] vert_ff, vert_in;
   logic       rsp_valid_ff, rsp_valid_in;
   report_type buttons_ff, buttons_in;
   logic [7:0] pad_ff, pad_in;
   logic       resync_ff, resync_in;

   assign raw_bytes = {req_byte5, req_byte4, req_byte3, req_byte2, req_byte1, req_byte0};

   for (genvar g = 0; g < NUM_BYTES; g++) begin : g_lane
      gpq_lane u_lane (
         .raw_byte   (raw_bytes[g]),
         .clear_byte (clear_bytes[g]),
         .is_ones    (lane_ones[g])
      );
   end

   gpq_merge u_merge (
      .clear_bytes (clear_bytes),
      .lane_ones   (lane_ones),
      .merged      (merged)
   );

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign accept     = req_valid & ~req_stall;
   assign resync_now = req_read_ok ? merged.all_ones : last_ones_ff;

   gpq_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .push   (accept & req_read_ok),
      .report (merged.report),
      .clear  (accept & resync_now),
      .view   (view)
   );

   always_comb begin
      shown   = delay_ff ? view.oldest : view.newest;
      pad_now = '0;
      if (jump_run_ff) begin
         pad_now[PAD_B]  = shown[REP_A] | shown[REP_B];
         pad_now[PAD_UP] = shown[REP_X] | shown[REP_Y] | shown[REP_UP];
      end else begin
         pad_now[PAD_C]     = shown[REP_A];
         pad_now[PAD_START] = shown[REP_START];
         pad_now[PAD_B]     = shown[REP_X] | shown[REP_B];
         pad_now[PAD_A]     = shown[REP_Y];
         pad_now[PAD_UP]    = shown[REP_UP];
      end
      pad_now[PAD_RIGHT] = shown[REP_RIGHT];
      pad_now[PAD_LEFT]  = shown[REP_LEFT];
      pad_now[PAD_DOWN]  = shown[REP_DOWN];
   end

   always_comb begin
      jump_run_in  = jump_run_ff;
      delay_in     = delay_ff;
      last_ones_in = last_ones_ff;
      horiz_in     = horiz_ff;
      vert_in      = vert_ff;
      buttons_in   = buttons_ff;
      pad_in       = pad_ff;
      resync_in    = resync_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (csr_write_en) begin
         case (csr_index)
            CSR_JUMP_RUN: jump_run_in = csr_write_data;
            CSR_DELAY:    delay_in    = csr_write_data;
            default:      ;
         endcase
      end

      if (accept) begin
         if (req_read_ok) begin
            last_ones_in = merged.all_ones;
         end
         // right/down step up, left/up step down, 2-bit wrap
         horiz_in     = horiz_ff + {1'b0, view.newest[REP_RIGHT]}
                                 - {1'b0, view.newest[REP_LEFT]};
         vert_in      = vert_ff + {1'b0, view.newest[REP_DOWN]}
                                - {1'b0, view.newest[REP_UP]};
         buttons_in   = view.newest;
         pad_in       = pad_now;
         resync_in    = resync_now;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jump_run_ff  <= 1'b0;
         delay_ff     <= 1'b0;
         last_ones_ff <= 1'b0;
         horiz_ff     <= '0;
         vert_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         jump_run_ff  <= jump_run_in;
         delay_ff     <= delay_in;
         last_ones_ff <= last_ones_in;
         horiz_ff     <= horiz_in;
         vert_ff      <= vert_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buttons_ff <= buttons_in;
      pad_ff     <= pad_in;
      resync_ff  <= resync_in;
   end

   // counters only move on acceptance, which also loads the response
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_buttons_now = buttons_ff;
   assign rsp_pad_pressed = pad_ff;
   assign rsp_horiz_phase = horiz_ff[0] ^ horiz_ff[1];
   assign rsp_horiz_quad  = horiz_ff[1];
   assign rsp_vert_phase  = vert_ff[0] ^ vert_ff[1];
   assign rsp_vert_quad   = vert_ff[1];
   assign rsp_resync      = resync_ff;

endmodule

FILE: sv/gpq_checker.sv
// Port-level checker for the pad and quadrature block, bound to the top level.
`include "gamepad_report_to_pad_and_quadrature_assert.svh"

module gpq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [14:0] rsp_buttons_now,
   input logic [7:0]  rsp_pad_pressed,
   input logic        rsp_horiz_phase,
   input logic        rsp_horiz_quad,
   input logic        rsp_vert_phase,
   input logic        rsp_vert_quad,
   input logic        rsp_resync
);

   logic        rsp_held;
   logic [27:0] rsp_payload;
   logic [1:0]  h_lines;
   logic [1:0]  v_lines;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_payload = {rsp_buttons_now, rsp_pad_pressed, rsp_horiz_phase, rsp_horiz_quad,
                         rsp_vert_phase, rsp_vert_quad, rsp_resync};
   assign h_lines     = {rsp_horiz_phase, rsp_horiz_quad};
   assign v_lines     = {rsp_vert_phase, rsp_vert_quad};

   // a stalled response holds
   `GPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))

   // nothing pending straight after reset
   `GPQ_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // resync only follows an all-ones poll, now or at the last read poll: no buttons
   `GPQ_ASSERT_NOW(a_resync_blank, clock, reset, rsp_valid && rsp_resync, rsp_buttons_now == 15'd0)

   // quadrature lines move one Gray step at most per response
   `GPQ_ASSERT_NEXT(a_horiz_gray, clock, reset, !reset, $countones(h_lines ^ $past(h_lines)) <= 1)
   `GPQ_ASSERT_NEXT(a_vert_gray, clock, reset, !reset, $countones(v_lines ^ $past(v_lines)) <= 1)

endmodule

bind gamepad_report_to_pad_and_quadrature gpq_checker u_gpq_checker (.*);
